// File: rtl/core/ihex_pkg.sv
// Shared types and constants of the Intel HEX record loader.
package ihex_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int STATUS_W = 3;
    localparam int MEM_SIZE_W = 17;
    localparam int INDEX_W = 9;

    localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RESET = 17'd8192;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_RETURN = 2'd2;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF = 8'h01;
    localparam logic [7:0] TYPE_EXT_LINEAR = 8'h04;

    localparam logic [STATUS_W-1:0] STATUS_NONE = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEX = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_HALTED = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic       colon;
        logic       hex_ok;
        logic [3:0] nibble;
    } token_t;

endpackage

// File: rtl/core/ihex_if.sv
// Channel interfaces for characters in and results out.
interface ihex_char_if;
    logic                         valid;
    logic                         ready;
    logic [ihex_pkg::CHAR_W-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface ihex_result_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [ihex_pkg::ADDR_W-1:0]   write_address;
    logic [ihex_pkg::DATA_W-1:0]   write_data;
    logic [ihex_pkg::STATUS_W-1:0] status;
    logic [ihex_pkg::ADDR_W-1:0]   max_address;

    modport source (output valid, output write_valid, output write_address,
                    output write_data, output status, output max_address,
                    input ready);
    modport sink (input valid, input write_valid, input write_address,
                  input write_data, input status, input max_address,
                  output ready);
endinterface

// File: rtl/core/ihex_front.sv
// Front end: accepts characters and classifies them into tokens for the queue.
module ihex_front
(
    ihex_char_if.sink         in_ch,
    input  logic              queue_full,
    output logic              push,
    output ihex_pkg::token_t  token
);

    logic [ihex_pkg::CHAR_W-1:0] c;

    assign c = in_ch.character;
    assign in_ch.ready = !queue_full;
    assign push = in_ch.valid && !queue_full;

    always_comb
    begin
        token.colon = (c == ihex_pkg::CHAR_COLON);
        if (c == ihex_pkg::CHAR_NEWLINE)
        begin
            token.kind = ihex_pkg::KIND_NEWLINE;
        end
        else if (c == ihex_pkg::CHAR_RETURN)
        begin
            token.kind = ihex_pkg::KIND_RETURN;
        end
        else
        begin
            token.kind = ihex_pkg::KIND_OTHER;
        end

        if (c >= 8'h30 && c <= 8'h39)
        begin
            token.hex_ok = 1'b1;
            token.nibble = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            token.hex_ok = 1'b1;
            token.nibble = c[3:0] + 4'd9;
        end
        else
        begin
            token.hex_ok = 1'b0;
            token.nibble = 4'd0;
        end
    end

endmodule

// File: rtl/core/ihex_queue.sv
// Short token queue between the front end and the back end.
module ihex_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ihex_pkg::token_t  push_token,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output ihex_pkg::token_t  head_token
);

    ihex_pkg::token_t                 slot_reg [ihex_pkg::QUEUE_DEPTH];
    logic [ihex_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [ihex_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [ihex_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [ihex_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [ihex_pkg::QUEUE_CW-1:0]    count_reg;
    logic [ihex_pkg::QUEUE_CW-1:0]    count_next;

    assign full = (count_reg == ihex_pkg::QUEUE_CW'(ihex_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head_token = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ihex_pkg::QUEUE_AW'(ihex_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ihex_pkg::QUEUE_AW'(ihex_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

// File: rtl/core/ihex_back.sv
// Back end: record state machine, byte assembly, checks and the result register.
module ihex_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ihex_pkg::MEM_SIZE_W-1:0]     cfg_write_data,
    input  logic                                queue_empty,
    input  ihex_pkg::token_t                    token,
    output logic                                pop,
    ihex_result_if.source                       out_ch
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_REC = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    localparam logic [ihex_pkg::INDEX_W-1:0] INDEX_MAX = '1;

    logic [ihex_pkg::MEM_SIZE_W-1:0] mem_size_reg;
    logic [1:0]                      phase_reg, phase_next;
    logic                            pending_reg, pending_next;
    logic [3:0]                      high_reg, high_next;
    logic [ihex_pkg::INDEX_W-1:0]    index_reg, index_next;
    logic [7:0]                      length_reg, length_next;
    logic [ihex_pkg::ADDR_W-1:0]     address_reg, address_next;
    logic [7:0]                      type_reg, type_next;
    logic [7:0]                      sum_reg, sum_next;
    logic [1:0]                      flags_reg, flags_next;
    logic [ihex_pkg::ADDR_W-1:0]     highest_reg, highest_next;

    logic                            out_valid_reg;
    logic                            write_valid_reg, write_valid_next;
    logic [ihex_pkg::ADDR_W-1:0]     write_address_reg, write_address_next;
    logic [ihex_pkg::DATA_W-1:0]     write_data_reg, write_data_next;
    logic [ihex_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            clear;
    logic [7:0]                      assembled;
    logic [ihex_pkg::INDEX_W-1:0]    offset;
    logic [ihex_pkg::MEM_SIZE_W-1:0] target;
    logic [ihex_pkg::STATUS_W-1:0]   verdict;

    assign pop = !queue_empty && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid = out_valid_reg;
    assign out_ch.write_valid = write_valid_reg;
    assign out_ch.write_address = write_address_reg;
    assign out_ch.write_data = write_data_reg;
    assign out_ch.status = status_reg;
    assign out_ch.max_address = highest_reg;

    assign assembled = {high_reg, token.nibble};
    assign offset = index_reg - ihex_pkg::INDEX_W'(4);
    assign target = {1'b0, address_reg} + ihex_pkg::MEM_SIZE_W'(offset);

    always_comb
    begin
        if (flags_reg[0] || pending_reg)
        begin
            verdict = ihex_pkg::STATUS_BAD_HEX;
        end
        else if (sum_reg != 8'd0)
        begin
            verdict = ihex_pkg::STATUS_CHECKSUM;
        end
        else if (type_reg != ihex_pkg::TYPE_DATA && type_reg != ihex_pkg::TYPE_EOF &&
                 type_reg != ihex_pkg::TYPE_EXT_LINEAR)
        begin
            verdict = ihex_pkg::STATUS_BAD_TYPE;
        end
        else if (flags_reg[1])
        begin
            verdict = ihex_pkg::STATUS_RANGE;
        end
        else
        begin
            verdict = ihex_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pending_next = pending_reg;
        high_next = high_reg;
        index_next = index_reg;
        length_next = length_reg;
        address_next = address_reg;
        type_next = type_reg;
        sum_next = sum_reg;
        flags_next = flags_reg;
        highest_next = highest_reg;
        write_valid_next = 1'b0;
        write_address_next = '0;
        write_data_next = '0;
        status_next = ihex_pkg::STATUS_NONE;
        clear = 1'b0;

        if (phase_reg == PH_HALT)
        begin
            status_next = ihex_pkg::STATUS_HALTED;
        end
        else if (token.kind == ihex_pkg::KIND_RETURN)
        begin
            status_next = ihex_pkg::STATUS_NONE;
        end
        else if (token.kind == ihex_pkg::KIND_NEWLINE)
        begin
            clear = 1'b1;
            if (phase_reg == PH_REC)
            begin
                status_next = verdict;
                phase_next = (verdict == ihex_pkg::STATUS_OK) ? PH_START : PH_HALT;
            end
            else
            begin
                phase_next = PH_START;
            end
        end
        else if (phase_reg == PH_START)
        begin
            clear = 1'b1;
            phase_next = token.colon ? PH_REC : PH_SKIP;
        end
        else if (phase_reg == PH_REC)
        begin
            if (!token.hex_ok)
            begin
                flags_next[0] = 1'b1;
            end
            if (!pending_reg)
            begin
                high_next = token.nibble;
                pending_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                sum_next = sum_reg + assembled;
                case (index_reg)
                    9'd0:
                    begin
                        length_next = assembled;
                    end
                    9'd1:
                    begin
                        address_next = {assembled, address_reg[7:0]};
                    end
                    9'd2:
                    begin
                        address_next = {address_reg[15:8], assembled};
                    end
                    9'd3:
                    begin
                        type_next = assembled;
                    end
                    default:
                    begin
                        if (type_reg == ihex_pkg::TYPE_DATA &&
                            offset < ihex_pkg::INDEX_W'(length_reg))
                        begin
                            if (target >= mem_size_reg || target[ihex_pkg::MEM_SIZE_W-1])
                            begin
                                flags_next[1] = 1'b1;
                            end
                            else
                            begin
                                write_valid_next = 1'b1;
                                write_address_next = target[ihex_pkg::ADDR_W-1:0];
                                write_data_next = assembled;
                                if (target[ihex_pkg::ADDR_W-1:0] > highest_reg)
                                begin
                                    highest_next = target[ihex_pkg::ADDR_W-1:0];
                                end
                            end
                        end
                    end
                endcase
                if (index_reg != INDEX_MAX)
                begin
                    index_next = index_reg + 1'b1;
                end
            end
        end

        if (clear)
        begin
            pending_next = 1'b0;
            high_next = '0;
            index_next = '0;
            length_next = '0;
            address_next = '0;
            type_next = '0;
            sum_next = '0;
            flags_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= ihex_pkg::MEM_SIZE_RESET;
            phase_reg <= PH_START;
            pending_reg <= 1'b0;
            high_reg <= '0;
            index_reg <= '0;
            length_reg <= '0;
            address_reg <= '0;
            type_reg <= '0;
            sum_reg <= '0;
            flags_reg <= '0;
            highest_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mem_size_reg <= cfg_write_data;
            end
            if (pop)
            begin
                phase_reg <= phase_next;
                pending_reg <= pending_next;
                high_reg <= high_next;
                index_reg <= index_next;
                length_reg <= length_next;
                address_reg <= address_next;
                type_reg <= type_next;
                sum_reg <= sum_next;
                flags_reg <= flags_next;
                highest_reg <= highest_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            write_valid_reg <= write_valid_next;
            write_address_reg <= write_address_next;
            write_data_reg <= write_data_next;
            status_reg <= status_next;
        end
    end

endmodule

// File: rtl/core/intel_hex_record_loader_top.sv
// Top level of the Intel HEX record loader: front end, token queue and back end.
// A character accepted into the token queue is popped by the back end once the output register is free,
// and that pop loads its result transaction into the output register, where it waits until taken.
// The back end handles one token per cycle, so one character per cycle is sustained while the
// output is taken; a stalled output fills the two-entry queue and then holds the input.
// Reset is asynchronous and active low: it empties the queue, returns the record state
// to line start, clears the highest address and sets the memory size to 8192.
module intel_hex_record_loader_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [ihex_pkg::MEM_SIZE_W-1:0]  cfg_write_data,
    ihex_char_if.sink                        in_ch,
    ihex_result_if.source                    out_ch
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    ihex_pkg::token_t  push_token;
    ihex_pkg::token_t  head_token;

    ihex_front u_front
    (
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    ihex_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head_token (head_token)
    );

    ihex_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .queue_empty    (queue_empty),
        .token          (head_token),
        .pop            (pop),
        .out_ch         (out_ch)
    );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the Intel HEX record loader: random and directed text with a checker.
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {LINE_START, IN_RECORD, SKIPPING, HALTED} line_phase_t;

    typedef struct packed {
        logic                          write_valid;
        logic [ihex_pkg::ADDR_W-1:0]   write_address;
        logic [ihex_pkg::DATA_W-1:0]   write_data;
        logic [ihex_pkg::STATUS_W-1:0] status;
        logic [ihex_pkg::ADDR_W-1:0]   max_address;
    } load_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [ihex_pkg::MEM_SIZE_W-1:0] cfg_write_data;

    ihex_char_if char_bus ();
    ihex_result_if result_bus ();

    intel_hex_record_loader_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (char_bus),
        .out_ch         (result_bus)
    );

    logic [ihex_pkg::CHAR_W-1:0] hex_text[$];
    load_result_t                due_results[$];
    load_result_t                got;
    load_result_t                want;
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    int                          send_gap_pct = 19;
    int                          ready_gap_pct = 57;

    logic [ihex_pkg::MEM_SIZE_W-1:0] mem_size_cfg = ihex_pkg::MEM_SIZE_RESET;
    line_phase_t                     line_phase = LINE_START;
    logic                            digit_pending = 1'b0;
    logic [3:0]                      upper_nibble = '0;
    logic [ihex_pkg::INDEX_W-1:0]    byte_count = '0;
    logic [7:0]                      rec_length = '0;
    logic [ihex_pkg::ADDR_W-1:0]     rec_address = '0;
    logic [7:0]                      hdr_type = '0;
    logic [7:0]                      checksum_acc = '0;
    logic                            bad_hex_seen = 1'b0;
    logic                            range_seen = 1'b0;
    logic [ihex_pkg::ADDR_W-1:0]     top_address = '0;

    always #5 clk = ~clk;

    function automatic void clear_record();
        digit_pending = 1'b0;
        upper_nibble = '0;
        byte_count = '0;
        rec_length = '0;
        rec_address = '0;
        hdr_type = '0;
        checksum_acc = '0;
        bad_hex_seen = 1'b0;
        range_seen = 1'b0;
    endfunction

    function automatic load_result_t decode_char(input logic [ihex_pkg::CHAR_W-1:0] c);
        load_result_t                  r;
        logic [4:0]                    nib;
        logic [7:0]                    value;
        logic [17:0]                   addr;
        logic [ihex_pkg::STATUS_W-1:0] verdict;
        r = '0;
        if (line_phase == HALTED)
            r.status = ihex_pkg::STATUS_HALTED;
        else if (c == ihex_pkg::CHAR_RETURN)
        begin
        end
        else if (c == ihex_pkg::CHAR_NEWLINE)
        begin
            if (line_phase == IN_RECORD)
            begin
                if (bad_hex_seen || digit_pending)
                    verdict = ihex_pkg::STATUS_BAD_HEX;
                else if (checksum_acc != 8'd0)
                    verdict = ihex_pkg::STATUS_CHECKSUM;
                else if (hdr_type != ihex_pkg::TYPE_DATA && hdr_type != ihex_pkg::TYPE_EOF
                         && hdr_type != ihex_pkg::TYPE_EXT_LINEAR)
                    verdict = ihex_pkg::STATUS_BAD_TYPE;
                else if (range_seen)
                    verdict = ihex_pkg::STATUS_RANGE;
                else
                    verdict = ihex_pkg::STATUS_OK;
                r.status = verdict;
                line_phase = (verdict == ihex_pkg::STATUS_OK) ? LINE_START : HALTED;
            end
            else
                line_phase = LINE_START;
            clear_record();
        end
        else if (line_phase == LINE_START)
        begin
            clear_record();
            line_phase = (c == ihex_pkg::CHAR_COLON) ? IN_RECORD : SKIPPING;
        end
        else if (line_phase == IN_RECORD)
        begin
            if (c >= "0" && c <= "9")
                nib = 5'(c - "0");
            else if (c >= "A" && c <= "F")
                nib = 5'(c - "A" + 8'd10);
            else if (c >= "a" && c <= "f")
                nib = 5'(c - "a" + 8'd10);
            else
                nib = 5'd16;
            if (nib[4])
            begin
                bad_hex_seen = 1'b1;
                nib = 5'd0;
            end
            if (!digit_pending)
            begin
                upper_nibble = nib[3:0];
                digit_pending = 1'b1;
            end
            else
            begin
                value = {upper_nibble, nib[3:0]};
                digit_pending = 1'b0;
                checksum_acc = checksum_acc + value;
                case (byte_count)
                    9'd0: rec_length = value;
                    9'd1: rec_address[15:8] = value;
                    9'd2: rec_address[7:0] = value;
                    9'd3: hdr_type = value;
                    default:
                    begin
                        if (hdr_type == ihex_pkg::TYPE_DATA
                            && (byte_count - 9'd4) < {1'b0, rec_length})
                        begin
                            addr = 18'(rec_address) + 18'(byte_count - 9'd4);
                            if (addr >= 18'(mem_size_cfg) || addr > 18'hFFFF)
                                range_seen = 1'b1;
                            else
                            begin
                                r.write_valid = 1'b1;
                                r.write_address = addr[15:0];
                                r.write_data = value;
                                if (addr[15:0] > top_address)
                                    top_address = addr[15:0];
                            end
                        end
                    end
                endcase
                if (byte_count != 9'd511)
                    byte_count = byte_count + 9'd1;
            end
        end
        r.max_address = top_address;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            char_bus.valid <= 1'b0;
        else
        begin
            if (char_bus.valid && char_bus.ready)
                due_results.push_back(decode_char(char_bus.character));
            if (!char_bus.valid || char_bus.ready)
            begin
                if (hex_text.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    char_bus.valid <= 1'b1;
                    char_bus.character <= hex_text.pop_front();
                end
                else
                begin
                    char_bus.valid <= 1'b0;
                    char_bus.character <= 8'($urandom);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.write_valid = result_bus.write_valid;
                got.write_address = result_bus.write_address;
                got.write_data = result_bus.write_data;
                got.status = result_bus.status;
                got.max_address = result_bus.max_address;
                if (due_results.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.write_valid !== want.write_valid)
                    begin
                        $error("write_valid: expected %0h, actual %0h",
                               want.write_valid, got.write_valid);
                        mismatch_count++;
                    end
                    if (got.write_address !== want.write_address)
                    begin
                        $error("write_address: expected %0h, actual %0h",
                               want.write_address, got.write_address);
                        mismatch_count++;
                    end
                    if (got.write_data !== want.write_data)
                    begin
                        $error("write_data: expected %0h, actual %0h",
                               want.write_data, got.write_data);
                        mismatch_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.max_address !== want.max_address)
                    begin
                        $error("max_address: expected %0h, actual %0h",
                               want.max_address, got.max_address);
                        mismatch_count++;
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= ready_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'("0" + n);
        return lower ? 8'("a" + n - 4'd10) : 8'("A" + n - 4'd10);
    endfunction

    task automatic push_char(input logic [7:0] c);
        hex_text.push_back(c);
    endtask

    task automatic push_byte(input logic [7:0] value);
        if ($urandom_range(99) < 3)
            push_char(ihex_pkg::CHAR_RETURN);
        push_char(hex_char(value[7:4], 1'($urandom_range(1))));
        if ($urandom_range(99) < 3)
            push_char(ihex_pkg::CHAR_RETURN);
        push_char(hex_char(value[3:0], 1'($urandom_range(1))));
    endtask

    task automatic end_line();
        if ($urandom_range(3) == 0)
            push_char(ihex_pkg::CHAR_RETURN);
        push_char(ihex_pkg::CHAR_NEWLINE);
    endtask

    task automatic push_record(input logic [7:0] length, input logic [15:0] address,
                               input logic [7:0] kind, input int body);
        logic [7:0] sum;
        logic [7:0] value;
        push_char(ihex_pkg::CHAR_COLON);
        push_byte(length);
        push_byte(address[15:8]);
        push_byte(address[7:0]);
        push_byte(kind);
        sum = length + address[15:8] + address[7:0] + kind;
        for (int i = 0; i < body; i++)
        begin
            value = 8'($urandom);
            push_byte(value);
            sum = sum + value;
        end
        push_byte(8'(-sum));
        end_line();
    endtask

    task automatic push_header_only(input int count);
        logic [7:0] sum;
        logic [7:0] value;
        sum = 8'd0;
        push_char(ihex_pkg::CHAR_COLON);
        for (int i = 0; i < count; i++)
        begin
            value = (i == count - 1) ? 8'(-sum) : 8'($urandom);
            push_byte(value);
            sum = sum + value;
        end
        end_line();
    endtask

    task automatic push_data_record();
        int limit;
        int length;
        int address;
        int body;
        limit = mem_size_cfg;
        length = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(16);
        if (length > limit)
            length = limit;
        address = $urandom_range(limit - length);
        if (address > 65535)
            address = 65535;
        case ($urandom_range(9))
            0: body = $urandom_range(length);
            1: body = length + $urandom_range(1, 6);
            default: body = length;
        endcase
        push_record(8'(length), 16'(address), ihex_pkg::TYPE_DATA, body);
    endtask

    task automatic push_noise_line();
        logic [7:0] c;
        int         count;
        do
            c = 8'($urandom_range(255));
        while (c == ihex_pkg::CHAR_NEWLINE || c == ihex_pkg::CHAR_RETURN
               || c == ihex_pkg::CHAR_COLON);
        push_char(c);
        count = $urandom_range(12);
        for (int i = 0; i < count; i++)
        begin
            do
                c = 8'($urandom_range(255));
            while (c == ihex_pkg::CHAR_NEWLINE);
            push_char(c);
        end
        push_char(ihex_pkg::CHAR_NEWLINE);
    endtask

    task automatic fill_text(input int budget);
        int start;
        int pick;
        start = hex_text.size();
        while (hex_text.size() - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                push_data_record();
            else if (pick < 60)
                push_record(8'($urandom), 16'($urandom), ihex_pkg::TYPE_EOF,
                            $urandom_range(4));
            else if (pick < 70)
                push_record(8'($urandom), 16'($urandom), ihex_pkg::TYPE_EXT_LINEAR,
                            $urandom_range(4));
            else if (pick < 80)
                push_noise_line();
            else if (pick < 85)
                push_char(ihex_pkg::CHAR_NEWLINE);
            else if (pick < 92)
                push_header_only($urandom_range(3));
            else
            begin
                push_char(ihex_pkg::CHAR_RETURN);
                push_data_record();
            end
        end
    endtask

    task automatic wait_drained();
        while (hex_text.size() != 0 || due_results.size() != 0 || char_bus.valid)
            @(negedge clk);
    endtask

    task automatic write_memory_size(input logic [ihex_pkg::MEM_SIZE_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        mem_size_cfg = value;
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int          sizes[6];
        logic [4:0]  flaws;
        logic [15:0] fail_addr;
        logic [7:0]  fail_type;
        logic [7:0]  fail_bytes[6];
        logic [7:0]  sum;
        logic [7:0]  bad;
        int          line_start;
        int          pos;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = ihex_pkg::MEM_SIZE_RESET;
        char_bus.valid = 1'b0;
        char_bus.character = '0;
        result_bus.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_header_only(0);
        push_char(ihex_pkg::CHAR_NEWLINE);
        push_char(ihex_pkg::CHAR_RETURN);
        push_char(ihex_pkg::CHAR_NEWLINE);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(ihex_pkg::CHAR_COLON);
        push_char(8'h7F);
        push_char(ihex_pkg::CHAR_NEWLINE);
        push_record(8'd1, 16'h0000, ihex_pkg::TYPE_DATA, 1);
        push_record(8'd1, 16'd8191, ihex_pkg::TYPE_DATA, 1);
        push_record(8'd16, 16'h0100, ihex_pkg::TYPE_DATA, 16);
        push_record(8'd2, 16'h0200, ihex_pkg::TYPE_DATA, 5);
        push_record(8'd4, 16'h0300, ihex_pkg::TYPE_DATA, 2);
        push_header_only(1);
        push_header_only(2);
        push_header_only(3);
        push_record(8'd0, 16'h0000, ihex_pkg::TYPE_EOF, 0);
        push_record(8'd2, 16'h0000, ihex_pkg::TYPE_EXT_LINEAR, 2);
        push_record(8'd255, 16'h0000, ihex_pkg::TYPE_DATA, 255);
        push_record(8'd2, 16'h1000, ihex_pkg::TYPE_DATA, 20);
        push_char(ihex_pkg::CHAR_RETURN);
        push_record(8'd3, 16'h0400, ihex_pkg::TYPE_DATA, 3);

        sizes[0] = 1;
        sizes[1] = $urandom_range(1, 65536);
        sizes[2] = $urandom_range(1, 255);
        sizes[3] = 8192;
        sizes[4] = $urandom_range(1, 65536);
        sizes[5] = 65536;

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            write_memory_size(17'(sizes[phase]));
            @(negedge clk);
            case (phase / 2)
                0:
                begin
                    send_gap_pct = 19;
                    ready_gap_pct = 57;
                end
                1:
                begin
                    send_gap_pct = 57;
                    ready_gap_pct = 19;
                end
                default:
                begin
                    send_gap_pct = 0;
                    ready_gap_pct = 0;
                end
            endcase
            if (phase == 5)
                push_record(8'd1, 16'hFFFF, ihex_pkg::TYPE_DATA, 1);
            fill_text(120);
        end

        // The closing record carries at least one fault, so the loader halts on it.
        flaws = 5'($urandom_range(1, 31));
        fail_addr = flaws[4] ? ((mem_size_cfg > 17'hFFFF) ? 16'hFFFF : 16'(mem_size_cfg - 1))
                             : 16'h0000;
        fail_type = ihex_pkg::TYPE_DATA;
        if (flaws[3])
        begin
            do
                fail_type = 8'($urandom_range(255));
            while (fail_type == ihex_pkg::TYPE_DATA || fail_type == ihex_pkg::TYPE_EOF
                   || fail_type == ihex_pkg::TYPE_EXT_LINEAR);
        end
        fail_bytes[0] = 8'd2;
        fail_bytes[1] = fail_addr[15:8];
        fail_bytes[2] = fail_addr[7:0];
        fail_bytes[3] = fail_type;
        fail_bytes[4] = 8'($urandom);
        fail_bytes[5] = 8'($urandom);
        sum = 8'd0;
        push_char(ihex_pkg::CHAR_COLON);
        line_start = hex_text.size();
        for (int i = 0; i < 6; i++)
        begin
            push_byte(fail_bytes[i]);
            sum = sum + fail_bytes[i];
        end
        push_byte(8'(-sum) + (flaws[2] ? 8'($urandom_range(1, 255)) : 8'd0));
        if (flaws[1])
            push_char(hex_char(4'($urandom_range(15)), 1'b0));
        if (flaws[0])
        begin
            do
                pos = $urandom_range(line_start, hex_text.size() - 1);
            while (hex_text[pos] == ihex_pkg::CHAR_RETURN);
            do
                bad = 8'($urandom_range(255));
            while ((bad >= "0" && bad <= "9") || (bad >= "A" && bad <= "F")
                   || (bad >= "a" && bad <= "f")
                   || bad == ihex_pkg::CHAR_NEWLINE || bad == ihex_pkg::CHAR_RETURN);
            hex_text[pos] = bad;
        end
        push_char(ihex_pkg::CHAR_NEWLINE);
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(3) == 0)
                push_char(ihex_pkg::CHAR_NEWLINE);
            else if ($urandom_range(3) == 0)
                push_char(ihex_pkg::CHAR_RETURN);
            else
                push_char(8'($urandom_range(255)));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ihex_pkg.sv
rtl/core/ihex_if.sv
rtl/core/ihex_front.sv
rtl/core/ihex_queue.sv
rtl/core/ihex_back.sv
rtl/core/intel_hex_record_loader_top.sv
sim/testbench.sv
